/* hdl/crossfade_overlap_add_assert.svh */
// Assertion macros for the crossfade overlap-add block.
// Used by the top level only; no other dependencies.
`ifndef CROSSFADE_OVERLAP_ADD_ASSERT_SVH
`define CROSSFADE_OVERLAP_ADD_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define COA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crossfade overlap-add same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define COA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crossfade overlap-add next-cycle check failed");

`endif

/* hdl/coa_pkg.sv */
// Shared types and constants for the crossfade overlap-add block.
// No dependencies; imported by every module of the block.
package coa_pkg;

   localparam int MAX_CHUNK    = 4096;
   localparam int ADDR_BITS    = $clog2(MAX_CHUNK);
   localparam int SAMPLE_BITS  = 16;
   localparam int LEN_BITS     = 13;
   localparam int GAIN_BITS    = 16;
   localparam int WIN_BITS     = 16;
   localparam int SUM_BITS     = 40;
   localparam int WEIGHT_BITS  = 28;
   localparam int ONE_Q15      = 32768;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int QUEUE_DEPTH  = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CHUNK_LEN = 2'd0,
      CSR_STEP_LEN  = 2'd1,
      CSR_FADE_LEN  = 2'd2,
      CSR_RAMP_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          first_of_stream;
      logic                          final_chunk;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          end_of_stream;
   } rsp_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]  chunk_len;
      logic [LEN_BITS-1:0]  step_len;
      logic [LEN_BITS-1:0]  fade_len;
      logic [GAIN_BITS-1:0] ramp_gain;
   } cfg_type;

   // One classified sample on its way from the front to the back.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          first;
      logic                          emit;
      logic                          eos;
      logic [ADDR_BITS-1:0]          addr;
      logic [WIN_BITS-1:0]           win;
   } work_type;

   typedef struct packed {
      logic clearing;
      logic pop_queue;
      logic load_rsp;
   } back_status_type;

endpackage

/* hdl/coa_front.sv */
// Front end: tracks chunk position, computes window value, address and emit flags.
// Depends on coa_pkg.
module coa_front (
   input  logic              clock,
   input  logic              reset,
   input  coa_pkg::cfg_type  cfg,
   input  logic              accept,
   input  coa_pkg::req_type  req,
   output coa_pkg::work_type work
);
   import coa_pkg::*;

   logic [ADDR_BITS-1:0]       base_ff, base_in;
   logic [LEN_BITS-1:0]        idx_ff, idx_in;
   logic [LEN_BITS-1:0]        c, s0, s, f, cf, j, k, m, idx0;
   logic [ADDR_BITS-1:0]       base0, base1;
   logic                       wrap, fade_out, fade_in, at_end, big, last;
   logic [LEN_BITS+GAIN_BITS-1:0] prod;
   logic [WIN_BITS-1:0]        win;

   // Clamp the registers to their legal ranges.
   always_comb begin
      c = cfg.chunk_len;
      if (c == '0) begin
         c = LEN_BITS'(1);
      end
      if (c > LEN_BITS'(MAX_CHUNK)) begin
         c = LEN_BITS'(MAX_CHUNK);
      end
      s0 = (cfg.step_len == '0) ? LEN_BITS'(1) : cfg.step_len;
      s  = (s0 > c) ? c : s0;
      f  = (cfg.fade_len > c) ? c : cfg.fade_len;
   end

   // Position of this sample, after a restart or a chunk wrap.
   always_comb begin
      idx0  = req.first_of_stream ? '0 : idx_ff;
      base0 = req.first_of_stream ? '0 : base_ff;
      wrap  = idx0 >= c;
      base1 = wrap ? base0 + s[ADDR_BITS-1:0] : base0;
      k     = wrap ? '0 : idx0;
   end

   // Window: one shared multiplier serves both ramps.
   always_comb begin
      cf       = c - f;
      j        = k - cf;
      fade_out = (f != '0) && (k >= cf);
      fade_in  = (f != '0) && (k < f) && !fade_out;
      m        = fade_out ? j : k;
      prod     = m * cfg.ramp_gain;
      at_end   = (f >= LEN_BITS'(2)) && (m == f - LEN_BITS'(1));
      big      = prod >= (LEN_BITS+GAIN_BITS)'(ONE_Q15);
      if (fade_out) begin
         win = (at_end || big) ? '0 :
               WIN_BITS'((LEN_BITS+GAIN_BITS)'(ONE_Q15) - prod);
      end else if (fade_in) begin
         win = (at_end || big) ? WIN_BITS'(ONE_Q15) : prod[WIN_BITS-1:0];
      end else begin
         win = WIN_BITS'(ONE_Q15);
      end
   end

   // Classification and next position.
   always_comb begin
      last        = k == c - LEN_BITS'(1);
      work.sample = req.sample_in;
      work.first  = req.first_of_stream;
      work.addr   = base1 + k[ADDR_BITS-1:0];
      work.emit   = req.final_chunk || (k < s);
      work.eos    = req.final_chunk && last;
      work.win    = win;
      if (last) begin
         base_in = req.final_chunk ? '0 : base1 + s[ADDR_BITS-1:0];
         idx_in  = '0;
      end else begin
         base_in = base1;
         idx_in  = k + LEN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         idx_ff  <= '0;
      end else if (accept) begin
         base_ff <= base_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

/* hdl/coa_queue.sv */
// Short queue of classified samples between the front and the back.
// Depends on coa_pkg.
module coa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  coa_pkg::work_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output coa_pkg::work_type rd_data,
   output logic              empty
);
   import coa_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/coa_back.sv */
// Back end: sum and weight memories, saturating accumulate, serial normalizing divide.
// Depends on coa_pkg.
module coa_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  coa_pkg::work_type        q_data,
   input  logic                     rsp_pop,
   output logic                     rsp_valid,
   output coa_pkg::rsp_type         rsp,
   output coa_pkg::back_status_type status
);
   import coa_pkg::*;

   localparam int REM_BITS  = WEIGHT_BITS + SAMPLE_BITS;
   localparam int QUO_BITS  = SAMPLE_BITS - 1;
   localparam int CNT_BITS  = $clog2(QUO_BITS);
   localparam int PROD_BITS = SAMPLE_BITS + WIN_BITS + 1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_ACC   = 8'b0000_1000,
      ST_CHECK = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_DONE  = 8'b0100_0000,
      ST_SPARE = 8'b1000_0000
   } state_type;

   logic signed [SUM_BITS-1:0] sum_mem    [MAX_CHUNK];
   logic [WEIGHT_BITS-1:0]     weight_mem [MAX_CHUNK];

   state_type                    state_ff, state_in;
   work_type                     work_ff;
   logic                         busy_ff;
   logic [ADDR_BITS-1:0]         clr_addr_ff;
   logic signed [SUM_BITS-1:0]   sum_rd_ff, acc_ff;
   logic [WEIGHT_BITS-1:0]       wt_rd_ff, den_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic [REM_BITS-1:0]          rem_ff, dsh_ff;
   logic [QUO_BITS-1:0]          quo_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic                         sat_ff, rsp_valid_ff;
   rsp_type                      rsp_ff;

   logic                         pop_q, load_rsp, mem_we;
   logic [ADDR_BITS-1:0]         mem_addr;
   logic signed [SUM_BITS-1:0]   mem_sum, acc_sat;
   logic [WEIGHT_BITS-1:0]       mem_wt, wt_sat, den;
   logic signed [SUM_BITS:0]     acc_ext;
   logic [WEIGHT_BITS:0]         wt_ext;
   logic [SUM_BITS:0]            mag;
   logic [REM_BITS-1:0]          num, trial;
   logic                         trial_ok;
   logic signed [SAMPLE_BITS-1:0] q_val;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Saturating accumulate of sample times window and of the window itself.
   always_comb begin
      acc_ext = {sum_rd_ff[SUM_BITS-1], sum_rd_ff} + (SUM_BITS+1)'(prod_ff);
      if (acc_ext[SUM_BITS] != acc_ext[SUM_BITS-1]) begin
         acc_sat = acc_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         acc_sat = acc_ext[SUM_BITS-1:0];
      end
      wt_ext = {1'b0, wt_rd_ff} + (WEIGHT_BITS+1)'(work_ff.win);
      wt_sat = wt_ext[WEIGHT_BITS] ? '1 : wt_ext[WEIGHT_BITS-1:0];
      den    = (wt_sat == '0) ? WEIGHT_BITS'(ONE_Q15) : wt_sat;
   end

   // Rounded numerator and one restoring divide step.
   always_comb begin
      mag      = acc_ff[SUM_BITS-1] ? (SUM_BITS+1)'(-(SUM_BITS+1)'(acc_ff))
                                    : (SUM_BITS+1)'(acc_ff);
      num      = REM_BITS'(mag) + REM_BITS'(den_ff >> 1);
      trial_ok = rem_ff >= dsh_ff;
      trial    = rem_ff - dsh_ff;
      if (sat_ff) begin
         q_val = acc_ff[SUM_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         q_val = acc_ff[SUM_BITS-1] ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      pop_q    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_BITS'(MAX_CHUNK - 1)) begin
               state_in = busy_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop_q    = 1'b1;
               state_in = q_data.first ? ST_CLEAR : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = work_ff.emit ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            state_in = (num >= (REM_BITS'(den_ff) << QUO_BITS)) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Single memory write port: clearing sweep or accumulate write-back.
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = work_ff.addr;
      mem_sum  = acc_sat;
      mem_wt   = wt_sat;
      if (state_ff == ST_CLEAR) begin
         mem_we   = 1'b1;
         mem_addr = clr_addr_ff;
         mem_sum  = '0;
         mem_wt   = '0;
      end else if (state_ff == ST_ACC) begin
         mem_we = 1'b1;
         if (work_ff.emit) begin
            mem_sum = '0;
            mem_wt  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_addr]    <= mem_sum;
         weight_mem[mem_addr] <= mem_wt;
      end
      if (state_ff == ST_READ) begin
         sum_rd_ff <= sum_mem[work_ff.addr];
         wt_rd_ff  <= weight_mem[work_ff.addr];
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (pop_q) begin
         work_ff <= q_data;
      end
      if (state_ff == ST_READ) begin
         prod_ff <= work_ff.sample * $signed({1'b0, work_ff.win});
      end
      if (state_ff == ST_ACC) begin
         acc_ff <= acc_sat;
         den_ff <= den;
      end
      if (state_ff == ST_CHECK) begin
         rem_ff <= num;
         dsh_ff <= REM_BITS'(den_ff) << (QUO_BITS - 1);
         quo_ff <= '0;
         cnt_ff <= CNT_BITS'(QUO_BITS - 1);
         sat_ff <= num >= (REM_BITS'(den_ff) << QUO_BITS);
      end
      if (state_ff == ST_DIV) begin
         if (trial_ok) begin
            rem_ff <= trial;
         end
         quo_ff <= {quo_ff[QUO_BITS-2:0], trial_ok};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (load_rsp) begin
         rsp_ff.sample_out    <= q_val;
         rsp_ff.end_of_stream <= work_ff.eos;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         busy_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop_q) begin
            busy_ff <= 1'b1;
         end else if (state_in == ST_IDLE) begin
            busy_ff <= 1'b0;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end else begin
            clr_addr_ff <= '0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clearing  = state_ff == ST_CLEAR;
   assign status.pop_queue = pop_q;
   assign status.load_rsp  = load_rsp;

endmodule

/* hdl/crossfade_overlap_add.sv */
// Top level of the crossfade overlap-add block: configuration registers and wiring.
// Depends on coa_pkg, coa_front, coa_queue, coa_back and the assertion macro header.
//
// Streaming weighted overlap-add with a linear crossfade. Samples enter through a
// queue-style port (push/full) and normalized results leave through another
// (empty/pop). A sample that produces no result passes through queue pop, memory
// read and accumulate in the back end; a sample that produces a result passes
// through queue pop, memory read, saturating accumulate, range check, 15 steps of
// the serial restoring divider and result load, skipping the divider steps when
// the quotient saturates, so the divider sets the sustained rate. A result that
// has not been popped holds the back end in its load step. A two-entry queue lets
// the front end accept new samples while the back end works. After reset, and on
// every sample flagged first_of_stream, the back end sweeps both 4096-entry stores
// to zero, one entry a cycle; full stays high during that sweep. Configuration
// writes are always accepted and must only be made while the block is idle.
module crossfade_overlap_add (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  coa_pkg::req_type                     req_data,
   output logic                                 empty,
   input  logic                                 pop,
   output coa_pkg::rsp_type                     rsp_data,
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [coa_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [coa_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import coa_pkg::*;

`include "crossfade_overlap_add_assert.svh"

   cfg_type          cfg_ff;
   work_type         front_work, q_data;
   logic             accept, q_full, q_empty, rsp_valid;
   back_status_type  back_st;

   // Configuration registers; every register index is writable.
   assign ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_len <= LEN_BITS'(1024);
         cfg_ff.step_len  <= LEN_BITS'(512);
         cfg_ff.fade_len  <= LEN_BITS'(512);
         cfg_ff.ramp_gain <= GAIN_BITS'(64);
      end else if (valid && ready) begin
         case (csr_index_type'(csr_index))
            CSR_CHUNK_LEN: cfg_ff.chunk_len <= csr_wdata[LEN_BITS-1:0];
            CSR_STEP_LEN:  cfg_ff.step_len  <= csr_wdata[LEN_BITS-1:0];
            CSR_FADE_LEN:  cfg_ff.fade_len  <= csr_wdata[LEN_BITS-1:0];
            CSR_RAMP_GAIN: cfg_ff.ramp_gain <= csr_wdata[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input transaction handshake.
   assign full   = q_full || back_st.clearing;
   assign accept = push && !full;
   assign empty  = !rsp_valid;

   coa_front u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .accept(accept),
      .req   (req_data),
      .work  (front_work)
   );

   coa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_data(front_work),
      .full   (q_full),
      .rd_en  (back_st.pop_queue),
      .rd_data(q_data),
      .empty  (q_empty)
   );

   coa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .rsp_pop  (pop),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_data),
      .status   (back_st)
   );

   // A finished result never overwrites one that has not been taken.
   `COA_ASSERT_IMPLY(a_no_rsp_overwrite, clock, reset, back_st.load_rsp, empty || pop)
   // The store sweep never consumes a queued sample.
   `COA_ASSERT_IMPLY(a_no_pop_in_clear, clock, reset, back_st.clearing, !back_st.pop_queue)
   // An accepted sample is held in the queue on the following cycle.
   `COA_ASSERT_NEXT(a_accept_lands, clock, reset, push && !full, !q_empty)

endmodule

/* verif/tb_crossfade_overlap_add.sv */
// Self-checking testbench for the crossfade overlap-add block.
// Depends on coa_pkg and the crossfade_overlap_add top level.
`timescale 1ns / 1ps

module tb_crossfade_overlap_add;
   import coa_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;
   logic valid = 1'b0;
   logic ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   crossfade_overlap_add u_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .valid(valid), .ready(ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow of the block: registers, stores and stream position.
   int unsigned chunk_len_reg = 1024, step_len_reg = 512, fade_len_reg = 512;
   int unsigned ramp_gain_reg = 64;
   longint mix_sum [MAX_CHUNK];
   longint unsigned mix_weight [MAX_CHUNK];
   int unsigned chunk_base = 0, chunk_pos = 0;

   req_type pending_samples [$];
   rsp_type expected_outputs [$];
   bit failed = 1'b0;
   bit no_idle = 1'b0;
   int send_gap = 0, pop_gap = 0;

   // Window value at chunk index k.
   function automatic longint unsigned fade_window(int unsigned k, int unsigned c,
                                                   int unsigned f, int unsigned g);
      longint unsigned w, v;
      int unsigned j;
      w = ONE_Q15;
      if (f > 0) begin
         if (k < f) begin
            v = longint'(k) * g;
            if (f >= 2 && k == f - 1) w = ONE_Q15;
            else w = (v >= ONE_Q15) ? ONE_Q15 : v;
         end
         if (k >= c - f) begin
            j = k - (c - f);
            v = longint'(j) * g;
            if (f >= 2 && j == f - 1) w = 0;
            else w = (v >= ONE_Q15) ? 0 : ONE_Q15 - v;
         end
      end
      return w;
   endfunction

   // Accumulate one accepted sample and queue its output, if any.
   function automatic void accumulate_sample(req_type item);
      int unsigned c, s, f, k, addr;
      longint unsigned w, d;
      longint acc, mag, q;
      bit last;
      rsp_type r;
      c = chunk_len_reg;
      if (c < 1) c = 1;
      if (c > MAX_CHUNK) c = MAX_CHUNK;
      s = step_len_reg;
      if (s < 1) s = 1;
      if (s > c) s = c;
      f = (fade_len_reg > c) ? c : fade_len_reg;
      if (item.first_of_stream) begin
         foreach (mix_sum[i]) begin
            mix_sum[i] = 0;
            mix_weight[i] = 0;
         end
         chunk_base = 0;
         chunk_pos = 0;
      end
      if (chunk_pos >= c) begin
         chunk_base = (chunk_base + s) % MAX_CHUNK;
         chunk_pos = 0;
      end
      k = chunk_pos;
      addr = (chunk_base + k) % MAX_CHUNK;
      w = fade_window(k, c, f, ramp_gain_reg);
      acc = mix_sum[addr] + longint'(item.sample_in) * longint'(w);
      if (acc > 64'sd549755813887) acc = 64'sd549755813887;
      if (acc < -64'sd549755813888) acc = -64'sd549755813888;
      mix_sum[addr] = acc;
      mix_weight[addr] = (mix_weight[addr] + w > 268435455) ? 268435455
                                                             : mix_weight[addr] + w;
      last = (k == c - 1);
      if (item.final_chunk || k < s) begin
         d = (mix_weight[addr] != 0) ? mix_weight[addr] : ONE_Q15;
         mag = (acc < 0) ? -acc : acc;
         q = (mag + longint'(d / 2)) / longint'(d);
         if (acc < 0) q = -q;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         r.sample_out = q[SAMPLE_BITS-1:0];
         r.end_of_stream = item.final_chunk && last;
         expected_outputs = {expected_outputs, r};
         mix_sum[addr] = 0;
         mix_weight[addr] = 0;
      end
      if (last) begin
         if (item.final_chunk) begin
            chunk_base = 0;
            chunk_pos = 0;
         end else begin
            chunk_base = (chunk_base + s) % MAX_CHUNK;
            chunk_pos = 0;
         end
      end else begin
         chunk_pos = k + 1;
      end
   endfunction

   // Sample driver: presents queued samples with random idle bursts.
   always @(posedge clock) begin
      bit next_push;
      if (!reset) begin
         next_push = push;
         if (push && !full) begin
            accumulate_sample(req_data);
            next_push = 1'b0;
         end
         if (!next_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() > 0) begin
               req_data <= pending_samples.pop_front();
               next_push = 1'b1;
               if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
            end
         end
         push <= next_push;
      end
   end

   // Output monitor: pops with random stalls and checks each transaction.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected output, expected none, actual %h", $time, rsp_data);
               failed = 1'b1;
            end else begin
               exp_r = expected_outputs.pop_front();
               if (rsp_data.sample_out !== exp_r.sample_out)
                  begin
                     $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                              $time, exp_r.sample_out, rsp_data.sample_out);
                     failed = 1'b1;
                  end
               if (rsp_data.end_of_stream !== exp_r.end_of_stream) begin
                  $display("%0t: end_of_stream mismatch, expected %0b, actual %0b",
                           $time, exp_r.end_of_stream, rsp_data.end_of_stream);
                  failed = 1'b1;
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) pop_gap = $urandom_range(1, 3);
         end
      end
   end

   // Configuration write; the shadow registers follow at the handshake.
   task automatic write_register(csr_index_type idx, int unsigned value);
      @(posedge clock);
      valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      do @(posedge clock); while (!ready);
      valid <= 1'b0;
      case (idx)
         CSR_CHUNK_LEN: chunk_len_reg = value & 16'h1FFF;
         CSR_STEP_LEN:  step_len_reg = value & 16'h1FFF;
         CSR_FADE_LEN:  fade_len_reg = value & 16'h1FFF;
         CSR_RAMP_GAIN: ramp_gain_reg = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   // Waits until every queued sample is in and every output is out.
   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || push || expected_outputs.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_BITS'(16'h7FFF);
         1: return SAMPLE_BITS'(16'h8000);
         2: return '0;
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // Queues about budget samples as streams of whole chunks of length c.
   task automatic queue_streams(int unsigned c, int budget, bit continue_first);
      int nchunks, n;
      req_type item;
      bit is_final;
      while (budget > 0) begin
         nchunks = $urandom_range(1, 5);
         for (int ch = 0; ch < nchunks && budget > 0; ch++) begin
            is_final = (ch == nchunks - 1);
            n = (c > budget) ? budget : c;
            for (int i = 0; i < n; i++) begin
               item.sample_in = pick_sample();
               item.first_of_stream = (ch == 0 && i == 0 && !continue_first);
               item.final_chunk = is_final;
               // Occasional broken sequences.
               if ($urandom_range(0, 39) == 0) item.final_chunk = ~item.final_chunk;
               if ($urandom_range(0, 79) == 0) item.first_of_stream = 1'b1;
               pending_samples = {pending_samples, item};
               budget--;
            end
            continue_first = 1'b0;
         end
      end
   endtask

   task automatic run_phase(int unsigned c, int unsigned s, int unsigned f,
                            int unsigned g, int budget);
      int unsigned c_eff;
      drain();
      write_register(CSR_CHUNK_LEN, c);
      write_register(CSR_STEP_LEN, s);
      write_register(CSR_FADE_LEN, f);
      write_register(CSR_RAMP_GAIN, g);
      c_eff = (c & 16'h1FFF);
      if (c_eff < 1) c_eff = 1;
      if (c_eff > MAX_CHUNK) c_eff = MAX_CHUNK;
      queue_streams(c_eff, budget, $urandom_range(0, 3) == 0);
   endtask

   initial begin
      int unsigned c, f;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Directed settings: extremes and clamped values.
      run_phase(4, 2, 2, 32768, 12);
      run_phase(2, 1, 0, 0, 6);
      run_phase(8, 4, 1, 100, 8);
      run_phase(0, 0, 8191, 65535, 4);
      run_phase(8191, 8191, 8191, 8, 40);
      run_phase(4096, 1, 4096, 8, 20);
      run_phase(6, 9, 3, 16384, 18);
      // Random settings, mostly small chunks.
      for (int p = 0; p < 24; p++) begin
         if (p == 23) begin
            drain();
            no_idle = 1'b1;
         end
         c = $urandom_range(2, 24);
         f = $urandom_range(0, c + 2);
         run_phase(c, $urandom_range(0, c + 2), f,
                   ($urandom_range(0, 1) && f > 1) ? 32768 / (f - 1) : $urandom_range(0, 65535),
                   48);
      end
      drain();
      if (!failed)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end

endmodule
